FILE: sv/prfc_pkg.sv
// Shared types and constants for the page replacement fault counter.
package prfc_pkg;

    // Fixed widths of the channel fields.
    localparam int PAGE_PORT_BITS = 16;
    localparam int SLOT_PORT_BITS = 5;
    localparam int FAULT_BITS     = 16;
    localparam int FRAMES_BITS    = 6;
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 8;

    localparam logic [FAULT_BITS-1:0] FAULT_MAX = '1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAMES_IN_USE = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_POLICY_MODE   = 4'd1;

    typedef enum logic {
        POLICY_FIFO = 1'b0,
        POLICY_LRU  = 1'b1
    } policy_t;

    typedef struct packed {
        logic [FRAMES_BITS-1:0] frames_in_use;
        policy_t                policy_mode;
    } cfg_t;

    typedef struct packed {
        logic                      was_hit;
        logic                      victim_valid;
        logic [PAGE_PORT_BITS-1:0] victim_page;
        logic [SLOT_PORT_BITS-1:0] frame_slot;
        logic [FAULT_BITS-1:0]     fault_total;
    } result_t;

endpackage

FILE: sv/prfc_cfg.sv
// Configuration registers of the page replacement fault counter.
module prfc_cfg
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [prfc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [prfc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output prfc_pkg::cfg_t                       cfg
);

    prfc_pkg::cfg_t cfg_reg;
    prfc_pkg::cfg_t cfg_next;

    // Writes must only arrive while the block is idle; the block does not enforce it, and cfg_ready is tied high.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                prfc_pkg::CFG_FRAMES_IN_USE:
                begin
                    cfg_next.frames_in_use = cfg_data[prfc_pkg::FRAMES_BITS-1:0];
                end
                prfc_pkg::CFG_POLICY_MODE:
                begin
                    cfg_next.policy_mode = prfc_pkg::policy_t'(cfg_data[0]);
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frames_in_use <= prfc_pkg::FRAMES_BITS'(4);
            cfg_reg.policy_mode   <= prfc_pkg::POLICY_FIFO;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: sv/prfc_core.sv
// Frame store, lookup, victim choice, recency update: one request a cycle on fire.
module prfc_core
#(
    parameter int MAX_FRAMES = 32,
    parameter int PAGE_BITS  = 16
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 fire,
    input  logic [prfc_pkg::PAGE_PORT_BITS-1:0]  page_number,
    input  logic                                 start_run,
    input  prfc_pkg::cfg_t                       cfg,
    output prfc_pkg::result_t                    result
);

    localparam int SW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int FW = $clog2(MAX_FRAMES + 1);
    localparam int FRAMES_LIM_W = prfc_pkg::FRAMES_BITS + 1;

    logic [PAGE_BITS-1:0]           page_mem_reg [MAX_FRAMES];
    logic [FW-1:0]                  rank_reg     [MAX_FRAMES];
    logic [FW-1:0]                  rank_next    [MAX_FRAMES];
    logic [FW-1:0]                  filled_reg, filled_next;
    logic [SW-1:0]                  oldest_reg, oldest_next;
    logic [prfc_pkg::FAULT_BITS-1:0] faults_reg, faults_next;

    logic [31:0]          page_wide;
    logic [PAGE_BITS-1:0] page_in;
    logic [FW-1:0]        filled_eff;
    logic [SW-1:0]        oldest_eff;
    logic [prfc_pkg::FAULT_BITS-1:0] faults_eff;
    logic [FRAMES_LIM_W-1:0] lim_wide;
    logic [FW-1:0]        limit;
    logic                 hit;
    logic [SW-1:0]        hit_slot;
    logic [FW-1:0]        cand_rank [MAX_FRAMES];
    logic [SW-1:0]        cand_slot [MAX_FRAMES];
    logic [SW-1:0]        lru_slot;
    logic [SW-1:0]        fifo_slot;
    logic                 fill;
    logic [SW-1:0]        slot;
    logic [FW-1:0]        touch_rank;
    logic [PAGE_BITS-1:0] victim;
    logic [31:0]          victim_wide;
    logic [31:0]          slot_wide;

    always_comb
    begin
        page_wide = 32'(page_number);
        page_in   = page_wide[PAGE_BITS-1:0];

        // A run start empties the frames before this reference is looked up.
        filled_eff = start_run ? '0 : filled_reg;
        oldest_eff = start_run ? '0 : oldest_reg;
        faults_eff = start_run ? '0 : faults_reg;

        lim_wide = FRAMES_LIM_W'(cfg.frames_in_use);
        if (lim_wide == '0)
        begin
            lim_wide = FRAMES_LIM_W'(1);
        end
        else if (lim_wide > FRAMES_LIM_W'(MAX_FRAMES))
        begin
            lim_wide = FRAMES_LIM_W'(MAX_FRAMES);
        end
        limit = FW'(lim_wide);

        // Lookup: lowest filled frame holding the page.
        hit      = 1'b0;
        hit_slot = '0;
        for (int i = MAX_FRAMES - 1; i >= 0; i--)
        begin
            if ((FW'(i) < filled_eff) && (page_mem_reg[i] == page_in))
            begin
                hit      = 1'b1;
                hit_slot = SW'(i);
            end
        end

        // Least recently used: a tree of compares finds the highest rank among
        // the filled frames. Ranks stop ageing at the frame count, so several
        // frames can share the top rank; the left side wins a tie, which gives
        // the lowest such slot.
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            cand_rank[i] = (FW'(i) < filled_eff) ? rank_reg[i] : '0;
            cand_slot[i] = SW'(i);
        end
        for (int step = 1; step < MAX_FRAMES; step = step * 2)
        begin
            for (int i = 0; i + step < MAX_FRAMES; i = i + 2 * step)
            begin
                if (cand_rank[i + step] > cand_rank[i])
                begin
                    cand_rank[i] = cand_rank[i + step];
                    cand_slot[i] = cand_slot[i + step];
                end
            end
        end
        lru_slot = cand_slot[0];

        fifo_slot = (FW'(oldest_eff) < filled_eff) ? oldest_eff : '0;

        fill        = !hit && (filled_eff < limit);
        oldest_next = oldest_eff;
        if (hit)
        begin
            slot = hit_slot;
        end
        else if (fill)
        begin
            slot = SW'(filled_eff);
        end
        else if (cfg.policy_mode == prfc_pkg::POLICY_FIFO)
        begin
            slot        = fifo_slot;
            oldest_next = ((FW'(fifo_slot) + FW'(1)) < filled_eff) ?
                          (fifo_slot + SW'(1)) : '0;
        end
        else
        begin
            slot = lru_slot;
        end

        filled_next = fill ? (filled_eff + FW'(1)) : filled_eff;

        // Recency: filled frames ranked below the touch rank age by one. A hit
        // uses the frame's own rank; a newly placed page uses the frame count,
        // so every other frame ages unless it already sits at that ceiling.
        touch_rank = hit ? rank_reg[slot] : FW'(MAX_FRAMES);
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            rank_next[i] = rank_reg[i];
            if ((FW'(i) < filled_next) && (SW'(i) != slot) &&
                (rank_reg[i] < touch_rank))
            begin
                rank_next[i] = rank_reg[i] + FW'(1);
            end
        end
        rank_next[slot] = '0;

        faults_next = faults_eff;
        if (!hit && (faults_eff != prfc_pkg::FAULT_MAX))
        begin
            faults_next = faults_eff + prfc_pkg::FAULT_BITS'(1);
        end

        victim      = (!hit && !fill) ? page_mem_reg[slot] : '0;
        victim_wide = 32'(victim);
        slot_wide   = 32'(slot);

        result.was_hit      = hit;
        result.victim_valid = !hit && !fill;
        result.victim_page  = victim_wide[prfc_pkg::PAGE_PORT_BITS-1:0];
        result.frame_slot   = slot_wide[prfc_pkg::SLOT_PORT_BITS-1:0];
        result.fault_total  = faults_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg <= '0;
            oldest_reg <= '0;
            faults_reg <= '0;
            for (int i = 0; i < MAX_FRAMES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            filled_reg <= filled_next;
            oldest_reg <= oldest_next;
            faults_reg <= faults_next;
            for (int i = 0; i < MAX_FRAMES; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && !hit)
        begin
            page_mem_reg[slot] <= page_in;
        end
    end

endmodule

FILE: sv/page_replacement_fault_counter_top.sv
// Top level of the page replacement fault counter: request and result registers.
//
// Each request names one page; the block looks it up in a fully associative set
// of frames, fills a free frame or evicts a victim (oldest inserted under FIFO,
// least recently used under LRU) and returns one result with hit or fault, the
// victim, the frame used and a saturating fault count. A request with
// start_run set empties the frames and clears the count before it is handled.
// The block takes one request every cycle while req_stall is low. An accepted
// request waits in the request register; when the result register can take it,
// the frame compare, victim choice and recency update run combinationally and
// their result is registered in the result register, where it is presented
// until taken. The request side stalls only while the request register holds a
// request and a result waits, stalled, in the result register.
// No clearing pass is needed after reset.
module page_replacement_fault_counter_top
#(
    parameter int MAX_FRAMES = 32,
    parameter int PAGE_BITS  = 16
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 req_valid,
    output logic                                 req_stall,
    input  logic [prfc_pkg::PAGE_PORT_BITS-1:0]  page_number,
    input  logic                                 start_run,

    output logic                                 rsp_valid,
    input  logic                                 rsp_stall,
    output logic                                 was_hit,
    output logic                                 victim_valid,
    output logic [prfc_pkg::PAGE_PORT_BITS-1:0]  victim_page,
    output logic [prfc_pkg::SLOT_PORT_BITS-1:0]  frame_slot,
    output logic [prfc_pkg::FAULT_BITS-1:0]      fault_total,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [prfc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [prfc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    prfc_pkg::cfg_t    cfg;
    prfc_pkg::result_t core_result;
    prfc_pkg::result_t result_reg;

    logic                                req_valid_reg;
    logic [prfc_pkg::PAGE_PORT_BITS-1:0] page_reg;
    logic                                start_reg;
    logic                                rsp_valid_reg;
    logic                                fire;

    // The held request is processed when the result register can take it.
    assign fire      = req_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = req_valid_reg && !fire;

    prfc_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    prfc_core
    #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS)
    )
    u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .page_number (page_reg),
        .start_run   (start_reg),
        .cfg         (cfg),
        .result      (core_result)
    );

    // Request register: refilled whenever it is empty or its request moves on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (!req_stall)
        begin
            req_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            page_reg  <= page_number;
            start_reg <= start_run;
        end
    end

    // Result register: holds its result until the far side takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= core_result;
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign was_hit      = result_reg.was_hit;
    assign victim_valid = result_reg.victim_valid;
    assign victim_page  = result_reg.victim_page;
    assign frame_slot   = result_reg.frame_slot;
    assign fault_total  = result_reg.fault_total;

endmodule
